[hdl/cpc_pkg.sv]
`timescale 1ns / 1ps

package cpc_pkg;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int THR_W = 8;
	localparam int CNT_W = 21;
	localparam int CFG_IDX_W = 2;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_W-1:0] cfg_word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_FRAME_WIDTH = 2'd0;
	localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;
	localparam cfg_idx_t REG_CONTRAST_THRESHOLD = 2'd2;

	localparam cfg_word_t WIDTH_RESET = 11'd320;
	localparam cfg_word_t HEIGHT_RESET = 11'd200;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd128;

	function automatic pix_t abs_diff(input pix_t a, input pix_t b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

[hdl/cpc_rowbuf.sv]
`timescale 1ns / 1ps

module cpc_rowbuf #(
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	input  logic                      pix_we,
	input  logic [$clog2(DEPTH)-1:0]  pix_addr,
	input  cpc_pkg::pix_t             pix_wdata,
	input  logic                      flag_we,
	input  logic [$clog2(DEPTH)-1:0]  flag_addr,
	input  logic                      flag_wdata,
	output cpc_pkg::pix_t             rd_pix,
	output logic                      rd_flag
);

	cpc_pkg::pix_t pix_mem [DEPTH];
	logic          flag_mem [DEPTH];

	cpc_pkg::pix_t pix_rd_q;
	logic          flag_rd_q;
	logic          pix_byp_q;
	logic          flag_byp_q;
	cpc_pkg::pix_t pix_byp_data_q;
	logic          flag_byp_data_q;

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_addr] <= pix_wdata;
		end
		if (flag_we) begin
			flag_mem[flag_addr] <= flag_wdata;
		end
		pix_rd_q <= pix_mem[rd_addr];
		flag_rd_q <= flag_mem[rd_addr];
		pix_byp_data_q <= pix_wdata;
		flag_byp_data_q <= flag_wdata;
	end

	// A write landing on the address being read in the same cycle is forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_byp_q <= 1'b0;
			flag_byp_q <= 1'b0;
		end else begin
			pix_byp_q <= pix_we && (pix_addr == rd_addr);
			flag_byp_q <= flag_we && (flag_addr == rd_addr);
		end
	end

	assign rd_pix = pix_byp_q ? pix_byp_data_q : pix_rd_q;
	assign rd_flag = flag_byp_q ? flag_byp_data_q : flag_rd_q;

endmodule

[hdl/contrast_pixel_counter_top.sv]
`timescale 1ns / 1ps

// Four-neighbor contrast pixel counter.
// Pixels of a frame enter in raster order on the pixel channel (pixel_valid,
// pixel_ready, pixel), one word per cycle at full rate. A pixel contrasts when
// its absolute difference to an in-frame left, right, upper or lower neighbor
// exceeds the threshold. With the last pixel of each frame one word appears on
// the count channel (count_valid, count_ready, contrast_count) in the cycle
// after that pixel is accepted; the frame state then restarts for the next
// frame. Throughput is one pixel per cycle: each pixel is handled by one pass
// of logic around a row buffer whose read for the next column is issued while
// the current pixel is accepted. The count sits in an output register; while
// that word waits with count_ready low the pixel channel is held off, and it
// takes pixels again in the cycle the receiver takes the word. Reset restores
// width 320, height 200 and threshold 128 and starts a new frame. Writing the
// width or height also restarts the frame. The user writes registers through
// cfg_we, cfg_index and cfg_data only while the block is idle; not enforced.
module contrast_pixel_counter_top #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  cpc_pkg::cfg_idx_t          cfg_index,
	input  cpc_pkg::cfg_word_t         cfg_data,
	input  logic                       pixel_valid,
	output logic                       pixel_ready,
	input  cpc_pkg::pix_t              pixel,
	output logic                       count_valid,
	input  logic                       count_ready,
	output cpc_pkg::cnt_t              contrast_count
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WCW = (CW + 1 > cpc_pkg::CFG_W) ? CW + 1 : cpc_pkg::CFG_W;
	localparam int WCH = (RW + 1 > cpc_pkg::CFG_W) ? RW + 1 : cpc_pkg::CFG_W;
	localparam logic [WCW-1:0] MAX_W = WCW'(MAX_WIDTH);
	localparam logic [WCH-1:0] MAX_H = WCH'(MAX_HEIGHT);

	cpc_pkg::cfg_word_t          width_q;
	cpc_pkg::cfg_word_t          height_q;
	logic [cpc_pkg::THR_W-1:0]   thr_q;

	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	cpc_pkg::pix_t  left_pix_q;
	logic           left_flag_q;
	logic           last_flag_q;
	cpc_pkg::cnt_t  cnt_q;
	logic           out_valid_q;
	cpc_pkg::cnt_t  out_cnt_q;

	logic [WCW-1:0] w_ext;
	logic [WCH-1:0] h_ext;
	logic [WCW-1:0] w_clamp;
	logic [WCH-1:0] h_clamp;
	logic [CW-1:0]  col_last;
	logic [RW-1:0]  row_last;

	logic           accept;
	logic           size_write;
	logic           is_last_col;
	logic           is_last_row;
	logic           frame_done;
	cpc_pkg::pix_t  up_pix;
	logic           up_flag_mem;
	logic           hz;
	logic           vt;
	logic           left_upd;
	logic           up_upd;
	logic           flag_now;
	logic [1:0]     add_cnt;
	cpc_pkg::cnt_t  cnt_sum;
	logic [CW-1:0]  col_next;
	logic [CW-1:0]  rd_addr;

	assign w_ext = WCW'(width_q);
	assign h_ext = WCH'(height_q);
	assign w_clamp = (w_ext == '0) ? WCW'(1) : ((w_ext > MAX_W) ? MAX_W : w_ext);
	assign h_clamp = (h_ext == '0) ? WCH'(1) : ((h_ext > MAX_H) ? MAX_H : h_ext);
	assign col_last = CW'(w_clamp - WCW'(1));
	assign row_last = RW'(h_clamp - WCH'(1));

	assign pixel_ready = !out_valid_q || count_ready;
	assign accept = pixel_valid && pixel_ready;
	assign size_write = cfg_we && (cfg_index == cpc_pkg::REG_FRAME_WIDTH
		|| cfg_index == cpc_pkg::REG_FRAME_HEIGHT);

	assign is_last_col = (col_q == col_last);
	assign is_last_row = (row_q == row_last);
	assign frame_done = is_last_col && is_last_row;

	always_comb begin
		hz = (col_q != '0) && (cpc_pkg::abs_diff(pixel, left_pix_q) > thr_q);
		vt = (row_q != '0) && (cpc_pkg::abs_diff(pixel, up_pix) > thr_q);
		left_upd = left_flag_q | hz;
		// The last column's flag is kept in a register, not in the row buffer.
		up_upd = (is_last_col ? last_flag_q : up_flag_mem) | vt;
		flag_now = hz | vt;
		add_cnt = {1'b0, (col_q != '0) && is_last_row && left_upd}
			+ {1'b0, (row_q != '0) && up_upd}
			+ {1'b0, frame_done && flag_now};
		cnt_sum = cnt_q + cpc_pkg::CNT_W'(add_cnt);
		col_next = is_last_col ? '0 : col_q + CW'(1);
		if (size_write) begin
			rd_addr = '0;
		end else if (accept) begin
			rd_addr = col_next;
		end else begin
			rd_addr = col_q;
		end
	end

	cpc_rowbuf #(
		.DEPTH(MAX_WIDTH)
	) u_rowbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (rd_addr),
		.pix_we     (accept),
		.pix_addr   (col_q),
		.pix_wdata  (pixel),
		.flag_we    (accept && (col_q != '0)),
		.flag_addr  (col_q - CW'(1)),
		.flag_wdata (left_upd),
		.rd_pix     (up_pix),
		.rd_flag    (up_flag_mem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cpc_pkg::WIDTH_RESET;
			height_q <= cpc_pkg::HEIGHT_RESET;
			thr_q <= cpc_pkg::THRESHOLD_RESET;
			col_q <= '0;
			row_q <= '0;
			left_pix_q <= '0;
			left_flag_q <= 1'b0;
			last_flag_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (count_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (is_last_col) begin
					last_flag_q <= flag_now;
				end
				if (frame_done) begin
					col_q <= '0;
					row_q <= '0;
					left_pix_q <= '0;
					left_flag_q <= 1'b0;
					cnt_q <= '0;
					out_valid_q <= 1'b1;
				end else if (is_last_col) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
					left_pix_q <= '0;
					left_flag_q <= 1'b0;
					cnt_q <= cnt_sum;
				end else begin
					col_q <= col_next;
					left_pix_q <= pixel;
					left_flag_q <= flag_now;
					cnt_q <= cnt_sum;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					cpc_pkg::REG_FRAME_WIDTH: begin
						width_q <= cfg_data;
					end
					cpc_pkg::REG_FRAME_HEIGHT: begin
						height_q <= cfg_data;
					end
					cpc_pkg::REG_CONTRAST_THRESHOLD: begin
						thr_q <= cfg_data[cpc_pkg::THR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (size_write) begin
				col_q <= '0;
				row_q <= '0;
				left_pix_q <= '0;
				left_flag_q <= 1'b0;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_done) begin
			out_cnt_q <= cnt_sum;
		end
	end

	assign count_valid = out_valid_q;
	assign contrast_count = out_cnt_q;

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= col_last)
		else $error("column position beyond frame width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= row_last)
		else $error("row position beyond frame height");

	a_count_from_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(count_valid) |-> $past(accept && frame_done))
		else $error("count word appeared without a frame-ending pixel");

	a_restart_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_done |=> col_q == '0 && row_q == '0 && cnt_q == '0)
		else $error("frame state not restarted after last pixel");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> out_valid_q && !count_ready)
		else $error("pixel channel stalled while output register free");

endmodule
